### hdl/energy_counter_power_meter_defines.svh
// ---------------------------------------------------------------------------
// energy counter power meter assertion macros
// shared concurrent assertion forms for the power meter rtl
// ---------------------------------------------------------------------------
`ifndef ENERGY_COUNTER_POWER_METER_DEFINES_SVH
`define ENERGY_COUNTER_POWER_METER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ECPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ECPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ecpm_pkg.sv
// ---------------------------------------------------------------------------
// ecpm_pkg
// shared widths, constants and control structs of the power meter
// ---------------------------------------------------------------------------
package ecpm_pkg;

  // field widths
  localparam int COUNT_W = 32;
  localparam int UNIT_W  = 5;
  localparam int NCH     = 3;
  localparam int CH_W    = 2;

  // microsecond-to-second scale folded with milliwatt scale
  localparam logic [29:0] NANO_PER_UNIT = 30'd1000000000;

  // configuration register map
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ENERGY_UNIT_EXP = 2'd0;
  localparam logic [UNIT_W-1:0]     UNIT_EXP_RESET       = 5'd16;

  // divider step count, one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  // channel codes
  localparam logic [CH_W-1:0] CH_PACKAGE = 2'd0;
  localparam logic [CH_W-1:0] CH_CORE    = 2'd1;
  localparam logic [CH_W-1:0] CH_MEMORY  = 2'd2;

  // sequencer to shared unit
  typedef struct packed {
    logic              start;
    logic [UNIT_W-1:0] unit_exp;
  } unit_ctl_t;

  // shared unit back to sequencer
  typedef struct packed {
    logic done;
    logic busy;
  } unit_stat_t;

endpackage

### hdl/ecpm_channels.sv
// ---------------------------------------------------------------------------
// ecpm channel interfaces
// valid/ready channels for the sample input and the power result
// ---------------------------------------------------------------------------
interface ecpm_in_if;
  import ecpm_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic               package_index;
  logic [COUNT_W-1:0] package_count;
  logic [COUNT_W-1:0] core_count;
  logic [COUNT_W-1:0] memory_count;
  logic [COUNT_W-1:0] elapsed_us;

  modport source (output valid, mode, package_index, package_count, core_count,
                  memory_count, elapsed_us, input ready);
  modport sink   (input valid, mode, package_index, package_count, core_count,
                  memory_count, elapsed_us, output ready);
endinterface

interface ecpm_out_if;
  import ecpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] package_mw;
  logic [COUNT_W-1:0] core_mw;
  logic [COUNT_W-1:0] memory_mw;

  modport source (output valid, package_mw, core_mw, memory_mw, input ready);
  modport sink   (input valid, package_mw, core_mw, memory_mw, output ready);
endinterface

### hdl/ecpm_cfg.sv
// ---------------------------------------------------------------------------
// ecpm_cfg
// apb-style register block holding the energy unit exponent
// ---------------------------------------------------------------------------
module ecpm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ecpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [ecpm_pkg::UNIT_W-1:0]     unit_exp
);
  import ecpm_pkg::*;

  logic [UNIT_W-1:0] unit_exp_r;
  logic [UNIT_W-1:0] unit_exp_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    unit_exp_nxt = unit_exp_r;
    if (wr_en && (paddr == ADDR_ENERGY_UNIT_EXP)) begin
      unit_exp_nxt = pwdata[UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_exp_r <= UNIT_EXP_RESET;
    end else begin
      unit_exp_r <= unit_exp_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENERGY_UNIT_EXP) begin
      prdata = {{(32-UNIT_W){1'b0}}, unit_exp_r};
    end
  end

  assign unit_exp = unit_exp_r;

endmodule

### hdl/ecpm_unit.sv
// ---------------------------------------------------------------------------
// ecpm_unit
// shared multiply, scale and bit-serial divide, one energy domain at a time
// ---------------------------------------------------------------------------
`include "energy_counter_power_meter_defines.svh"

module ecpm_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ecpm_pkg::unit_ctl_t          ctl,
  input  logic [ecpm_pkg::COUNT_W-1:0] delta,
  input  logic [ecpm_pkg::COUNT_W-1:0] divisor,
  output ecpm_pkg::unit_stat_t         stat,
  output logic [ecpm_pkg::COUNT_W-1:0] result
);
  import ecpm_pkg::*;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_SHF  = 2'd2;
  localparam logic [1:0] U_DIV  = 2'd3;

  logic [1:0]           st_r, st_nxt;
  logic [61:0]          prod_r, prod_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [61:0]          prod_w;
  logic [61:0]          num_w;
  logic [29:0]          num_hi;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 ge;

  // delta times 1e9, at most 62 bits
  assign prod_w = 62'(delta) * 62'(NANO_PER_UNIT);

  // divide by 2^exp first, then by elapsed time
  assign num_w  = prod_r >> ctl.unit_exp;
  assign num_hi = num_w[61:32];

  // one restoring divide step
  assign trial = {rem_r, quo_r[COUNT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    st_nxt   = st_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      U_IDLE: begin
        if (ctl.start) begin
          st_nxt = U_MUL;
        end
      end
      U_MUL: begin
        prod_nxt = prod_w;
        st_nxt   = U_SHF;
      end
      U_SHF: begin
        // high part at or above divisor means quotient beyond 32 bits
        if ({2'b00, num_hi} >= divisor) begin
          quo_nxt  = '1;
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end else begin
          rem_nxt = {2'b00, num_hi};
          quo_nxt = num_w[31:0];
          cnt_nxt = '0;
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quo_nxt = {quo_r[COUNT_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign stat.done = done_r;
  assign stat.busy = (st_r != U_IDLE);
  assign result    = quo_r;

  // checks
  `ECPM_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, st_r == U_DIV, rem_r < divisor,
    "partial remainder not below divisor")
  `ECPM_ASSERT_NOW(a_start_when_idle, clk, rst_n, ctl.start, st_r == U_IDLE,
    "unit started while busy")
  `ECPM_ASSERT_NEXT(a_done_single, clk, rst_n, done_r, !done_r && st_r == U_IDLE,
    "done held for more than one cycle")

endmodule

### hdl/energy_counter_power_meter.sv
// ---------------------------------------------------------------------------
// energy_counter_power_meter
// power from energy counter deltas over elapsed time, three domains
// ---------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          mode, package_index, three counts, elapsed_us
//  out_ch   out  valid/ready          package_mw, core_mw, memory_mw
//  cfg_*    in   apb setup + access   energy_unit_exp at byte address 0
//
//  measure mode runs from accept to the next accept as three passes through
//  the shared unit (start, multiply, scale, a 32-step divide one bit a
//  cycle, done), then parks the result in the output register.
//  a pass that saturates at the scale step skips the divide.
//  baseline mode, zero elapsed time or an unknown package skip the unit.
//  in_ch.ready is low while an item is in work or its result cannot be parked.
//  synchronous active-low reset clears stored readings and the exponent to 16.
// ---------------------------------------------------------------------------
`include "energy_counter_power_meter_defines.svh"

module energy_counter_power_meter #(
  parameter int PACKAGES = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ecpm_in_if.sink                         in_ch,
  ecpm_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ecpm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import ecpm_pkg::*;

  localparam int IDX_W = (PACKAGES > 1) ? $clog2(PACKAGES) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [COUNT_W-1:0] prev_r [NCH][PACKAGES];
  logic [COUNT_W-1:0] delta_r [NCH];
  logic [COUNT_W-1:0] res_r [NCH];
  logic [COUNT_W-1:0] elapsed_r;
  logic               skip_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_pkg_r, out_core_r, out_mem_r;

  logic [COUNT_W-1:0] cur_cnt [NCH];
  logic               accept;
  logic               idx_ok;
  logic [IDX_W-1:0]   sel;
  logic               load_out;
  logic [UNIT_W-1:0]  unit_exp;
  unit_ctl_t          unit_ctl;
  unit_stat_t         unit_stat;
  logic [COUNT_W-1:0] unit_result;

  // configuration registers
  ecpm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .unit_exp (unit_exp)
  );

  // input transaction decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_ok      = (32'(in_ch.package_index) < PACKAGES);
  assign sel         = idx_ok ? IDX_W'(in_ch.package_index) : '0;
  assign cur_cnt[CH_PACKAGE] = in_ch.package_count;
  assign cur_cnt[CH_CORE]    = in_ch.core_count;
  assign cur_cnt[CH_MEMORY]  = in_ch.memory_count;

  // result parks in the output register once it is free
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ch_nxt = CH_PACKAGE;
          if (!in_ch.mode || !idx_ok || (in_ch.elapsed_us == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (unit_stat.done) begin
          if (ch_r == CH_MEMORY) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= CH_PACKAGE;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // stored readings per package, replaced on every accepted sample with a known package index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        for (int p = 0; p < PACKAGES; p++) begin
          prev_r[c][p] <= '0;
        end
      end
    end else if (accept && idx_ok) begin
      for (int c = 0; c < NCH; c++) begin
        prev_r[c][sel] <= cur_cnt[c];
      end
    end
  end

  // wrapped deltas and per-domain results
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < NCH; c++) begin
        delta_r[c] <= cur_cnt[c] - prev_r[c][sel];
        res_r[c]   <= '0;
      end
      elapsed_r <= in_ch.elapsed_us;
      skip_r    <= !in_ch.mode || !idx_ok || (in_ch.elapsed_us == '0);
    end else if ((state_r == S_WAIT) && unit_stat.done) begin
      res_r[ch_r] <= unit_result;
    end
  end

  // shared arithmetic unit
  assign unit_ctl.start    = (state_r == S_START);
  assign unit_ctl.unit_exp = unit_exp;

  ecpm_unit u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (unit_ctl),
    .delta   (delta_r[ch_r]),
    .divisor (elapsed_r),
    .stat    (unit_stat),
    .result  (unit_result)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pkg_r  <= res_r[CH_PACKAGE];
      out_core_r <= res_r[CH_CORE];
      out_mem_r  <= res_r[CH_MEMORY];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.package_mw = out_pkg_r;
  assign out_ch.core_mw    = out_core_r;
  assign out_ch.memory_mw  = out_mem_r;

  // checks
  `ECPM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ch.ready,
    "new sample taken while one is in work")
  `ECPM_ASSERT_NEXT(a_skip_gives_zero, clk, rst_n, load_out && skip_r,
    out_ch.valid && out_ch.package_mw == '0 && out_ch.core_mw == '0 && out_ch.memory_mw == '0,
    "skipped sample gave nonzero power")
  `ECPM_ASSERT_NOW(a_unit_idle_outside_wait, clk, rst_n,
    state_r == S_IDLE || state_r == S_DONE, !unit_stat.busy,
    "shared unit busy outside a calculation")

endmodule

### verif/energy_counter_power_meter_test.sv
// ---------------------------------------------------------------------------
// energy_counter_power_meter_test
// self-checking bench for the energy counter power meter: samples of three
// energy counters go in over a valid/ready channel, each accepted sample is
// turned into an expected milliwatt triple by a local predictor, and every
// result transaction is compared field by field, over several energy units
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module energy_counter_power_meter_test;
  import ecpm_pkg::*;

  localparam int          NUM_PACKAGES = 2;
  localparam logic        MODE_BASELINE = 1'b0;
  localparam logic        MODE_MEASURE  = 1'b1;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam logic [63:0] NJ_PER_MW_US  = 64'd1000000000;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          DRAIN_CYCLES  = 150;
  localparam int          LONG_HOLD     = 500;
  localparam int          PHASE_ITEMS   = 150;

  typedef struct packed {
    logic               mode;
    logic               package_index;
    logic [COUNT_W-1:0] package_count;
    logic [COUNT_W-1:0] core_count;
    logic [COUNT_W-1:0] memory_count;
    logic [COUNT_W-1:0] elapsed_us;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] package_mw;
    logic [COUNT_W-1:0] core_mw;
    logic [COUNT_W-1:0] memory_mw;
  } power_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  ecpm_in_if  in_ch ();
  ecpm_out_if out_ch ();

  energy_counter_power_meter #(
    .PACKAGES(NUM_PACKAGES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: stored readings per package and the energy unit
  logic [COUNT_W-1:0] stored_counts[NUM_PACKAGES][NCH];
  logic [UNIT_W-1:0]  unit_exp_model;

  // samples waiting for the driver, power triples waiting for the block
  sample_t pending_samples[$];
  power_t  expected_power[$];

  // last counts handed to the driver, so random samples can step from them
  logic [COUNT_W-1:0] gen_last_count[NUM_PACKAGES][NCH];

  int mismatch_count = 0;
  int cycle_count = 0;

  // power in mW = floor(delta * 1e9 / (elapsed_us * 2^exp)), saturated
  function automatic logic [COUNT_W-1:0] milliwatts(input logic [COUNT_W-1:0] earlier,
                                                     input logic [COUNT_W-1:0] later,
                                                     input logic [COUNT_W-1:0] elapsed);
    logic [COUNT_W-1:0] delta;
    logic [63:0]        energy_nj;
    logic [63:0]        scaled_time;
    logic [63:0]        quotient;
    delta = later - earlier;
    if (elapsed == '0) return '0;
    energy_nj   = {32'd0, delta} * NJ_PER_MW_US;
    scaled_time = {32'd0, elapsed} << unit_exp_model;
    quotient    = energy_nj / scaled_time;
    return (quotient > {32'd0, ALL_ONES}) ? ALL_ONES : quotient[COUNT_W-1:0];
  endfunction

  // expected result of one accepted sample, then the baseline moves on
  task automatic predict_power(input sample_t s);
    power_t p;
    p = '0;
    if (s.mode == MODE_MEASURE) begin
      p.package_mw = milliwatts(stored_counts[s.package_index][CH_PACKAGE], s.package_count,
                                s.elapsed_us);
      p.core_mw    = milliwatts(stored_counts[s.package_index][CH_CORE], s.core_count,
                                s.elapsed_us);
      p.memory_mw  = milliwatts(stored_counts[s.package_index][CH_MEMORY], s.memory_count,
                                s.elapsed_us);
    end
    stored_counts[s.package_index][CH_PACKAGE] = s.package_count;
    stored_counts[s.package_index][CH_CORE]    = s.core_count;
    stored_counts[s.package_index][CH_MEMORY]  = s.memory_count;
    expected_power.push_back(p);
  endtask

  task automatic report_field(input string field, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
    if (expected_value !== actual_value) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)", $time, field,
               expected_value, expected_value, actual_value, actual_value);
    end
  endtask

  task automatic queue_sample(input logic mode, input logic idx, input logic [31:0] pkg,
                              input logic [31:0] core, input logic [31:0] mem,
                              input logic [31:0] elapsed);
    sample_t s;
    s.mode          = mode;
    s.package_index = idx;
    s.package_count = pkg;
    s.core_count    = core;
    s.memory_count  = mem;
    s.elapsed_us    = elapsed;
    gen_last_count[idx][CH_PACKAGE] = pkg;
    gen_last_count[idx][CH_CORE]    = core;
    gen_last_count[idx][CH_MEMORY]  = mem;
    pending_samples.push_back(s);
  endtask

  // log-spread magnitude so quotients land anywhere from zero to saturation
  function automatic logic [31:0] spread_value();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // one apb transfer: setup phase, then access until pready
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_unit_exp();
    logic [31:0] rdata;
    cfg_access(1'b0, ADDR_ENERGY_UNIT_EXP, '0, rdata);
    report_field("energy_unit_exp readback", {27'd0, unit_exp_model}, rdata);
  endtask

  // upper write data bits are junk, only the low five bits count
  task automatic set_unit_exp(input logic [UNIT_W-1:0] value);
    logic [31:0] rdata;
    cfg_access(1'b1, ADDR_ENERGY_UNIT_EXP, ($urandom & ~32'h1F) | {27'd0, value}, rdata);
    unit_exp_model = value;
    check_unit_exp();
  endtask

  // wait until the block holds no transaction at all
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_ch.valid || expected_power.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  sample_t offered;
  int      burst_left;
  int      gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_power(offered);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          offered = pending_samples.pop_front();
          in_ch.mode          <= offered.mode;
          in_ch.package_index <= offered.package_index;
          in_ch.package_count <= offered.package_count;
          in_ch.core_count    <= offered.core_count;
          in_ch.memory_count  <= offered.memory_count;
          in_ch.elapsed_us    <= offered.elapsed_us;
          in_ch.valid         <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: alternating ready runs and stalls, plus long hold-offs
  int   results_seen;
  int   long_hold_mark;
  int   hold_left;
  int   run_left;
  logic rx_taking;
  power_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      results_seen   = 0;
      long_hold_mark = 150;
      hold_left      = 0;
      run_left       = 0;
      rx_taking      = 1'b0;
    end else begin
      // result transaction check
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_power.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing, actual %h %h %h",
                   $time, out_ch.package_mw, out_ch.core_mw, out_ch.memory_mw);
        end else begin
          head = expected_power.pop_front();
          report_field("package_mw", head.package_mw, out_ch.package_mw);
          report_field("core_mw", head.core_mw, out_ch.core_mw);
          report_field("memory_mw", head.memory_mw, out_ch.memory_mw);
        end
      end
      // ready pattern for the next cycle
      if (results_seen >= long_hold_mark) begin
        hold_left = LONG_HOLD;
        long_hold_mark += 550;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_taking = !rx_taking;
          if (rx_taking) run_left = $urandom_range(1, 40);
          else run_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (run_left > 0) run_left--;
        out_ch.ready <= rx_taking || run_left == 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_power.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus and phase control
  initial begin
    int          ph;
    int          n;
    int          c;
    logic        idx;
    logic        mode;
    logic [4:0]  exp_sel;
    logic [31:0] next_count[NCH];
    logic [31:0] elapsed;

    rst_n               = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_BASELINE;
    in_ch.package_index = 1'b0;
    in_ch.package_count = '0;
    in_ch.core_count    = '0;
    in_ch.memory_count  = '0;
    in_ch.elapsed_us    = '0;
    out_ch.ready        = 1'b0;
    unit_exp_model      = UNIT_EXP_RESET;
    for (int p = 0; p < NUM_PACKAGES; p++) begin
      for (int k = 0; k < NCH; k++) begin
        stored_counts[p][k]  = '0;
        gen_last_count[p][k] = '0;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_unit_exp();

    // directed, reset unit: baselines, 1000 J/s, zero elapsed, exact rollover
    queue_sample(MODE_BASELINE, 1'b0, '0, '0, '0, '0);
    queue_sample(MODE_MEASURE, 1'b0, '0, '0, '0, 32'd1000);
    queue_sample(MODE_MEASURE, 1'b0, 32'd65536000, 32'd65536, 32'd1, 32'd1000000);
    queue_sample(MODE_MEASURE, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '0);
    queue_sample(MODE_BASELINE, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    queue_sample(MODE_MEASURE, 1'b1, '0, 32'd1, ALL_ONES, 32'd1);
    queue_sample(MODE_MEASURE, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'd1);
    queue_sample(MODE_MEASURE, 1'b0, 32'h1234_5677, 32'h9ABC_DEEF, 32'h0F0F_0F0E, ALL_ONES);
    wait_idle();

    // directed, finest unit
    set_unit_exp(5'd0);
    queue_sample(MODE_BASELINE, 1'b0, '0, '0, '0, 32'd5);
    queue_sample(MODE_MEASURE, 1'b0, ALL_ONES, 32'd1000, 32'd3, ALL_ONES);
    queue_sample(MODE_MEASURE, 1'b1, 32'h8000_0000, 32'h8000_0002, 32'hFFFF_FFFF, 32'd1);
    queue_sample(MODE_MEASURE, 1'b1, 32'h8000_0005, 32'h8000_0002, '0, 32'd1);
    wait_idle();

    // directed, coarsest unit
    set_unit_exp(5'd31);
    queue_sample(MODE_MEASURE, 1'b0, 32'hFFFF_FFFE, 32'd999, 32'd2, 32'd1);
    queue_sample(MODE_MEASURE, 1'b0, 32'hFFFF_FFFF, 32'd1000, 32'd3, ALL_ONES);
    queue_sample(MODE_BASELINE, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'd7);
    queue_sample(MODE_MEASURE, 1'b0, 32'hD555_5555, 32'h2AAA_AAAA, 32'h3333_3334, 32'd1);
    wait_idle();

    // random phases, one energy unit each; each ends with a full drain
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       exp_sel = 5'd0;
        1:       exp_sel = 5'd31;
        2:       exp_sel = UNIT_EXP_RESET;
        3:       exp_sel = 5'd7;
        default: exp_sel = UNIT_W'($urandom_range(0, 31));
      endcase
      set_unit_exp(exp_sel);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        idx  = 1'($urandom_range(0, NUM_PACKAGES - 1));
        mode = ($urandom_range(0, 4) == 0) ? MODE_BASELINE : MODE_MEASURE;
        c    = $urandom_range(0, 9);
        for (int k = 0; k < NCH; k++) begin
          // mostly counters that step forward, sometimes unrelated readings
          if (c == 0) next_count[k] = $urandom;
          else next_count[k] = gen_last_count[idx][k] + spread_value();
        end
        elapsed = ($urandom_range(0, 19) == 0) ? '0 : spread_value();
        queue_sample(mode, idx, next_count[CH_PACKAGE], next_count[CH_CORE],
                     next_count[CH_MEMORY], elapsed);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_power.size() != 0) begin
      mismatch_count++;
      $display("%0t: results never arrived, expected %0d more, actual 0", $time,
               expected_power.size());
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### energy_counter_power_meter.f
+incdir+hdl
hdl/ecpm_pkg.sv
hdl/ecpm_channels.sv
hdl/ecpm_cfg.sv
hdl/ecpm_unit.sv
hdl/energy_counter_power_meter.sv
verif/energy_counter_power_meter_test.sv
